// ----- design/gillespie_birth_death_stepper_assert.svh -----
// Assertion macros used by the stepper back end.
`ifndef GILLESPIE_BIRTH_DEATH_STEPPER_ASSERT_SVH
`define GILLESPIE_BIRTH_DEATH_STEPPER_ASSERT_SVH

// Property checked on every clock edge outside reset.
`define GBD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property that must never hold outside reset.
`define GBD_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`endif

// ----- design/gbd_pkg.sv -----
// Shared types and constants of the birth-death stepper.
package gbd_pkg;

  localparam int TIME_W    = 48;
  localparam int DRAW_W    = 32;
  localparam int POP_W     = 11;
  localparam int ZEAL_W    = 10;
  localparam int ALPHA_W   = 17;
  localparam int OUT_CNT_W = 10;
  localparam int LOG_BITS  = 26;
  localparam int NEG_LN_W  = 38;
  localparam int CFG_IDX_W = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int DEF_MAX_POPULATION     = 1024;
  localparam int DEF_TIME_FRACTION_BITS = 24;

  localparam logic [31:0]        LN2_Q32   = 32'd2977044472;
  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;
  localparam logic [TIME_W-1:0]  TIME_MAX  = 48'hFFFF_FFFF_FFFF;

  localparam logic [POP_W-1:0]   RST_POPULATION = 11'd100;
  localparam logic [ZEAL_W-1:0]  RST_ZEALOT     = 10'd1;
  localparam logic [ALPHA_W-1:0] RST_ALPHA      = 17'd32768;
  localparam logic [TIME_W-1:0]  RST_TIME_LIMIT = 48'd1677721600000;

  localparam logic [CFG_IDX_W-1:0] REG_POPULATION = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ZEALOT     = 8'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA      = 8'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_LIMIT = 8'd3;

  localparam logic OUTCOME_FIXATION = 1'b0;
  localparam logic OUTCOME_TIMEOUT  = 1'b1;

  typedef struct packed {
    logic [POP_W-1:0]   population_size;
    logic [ZEAL_W-1:0]  zealot_count;
    logic [ALPHA_W-1:0] payoff_alpha;
    logic [TIME_W-1:0]  time_limit;
  } cfg_t;

  typedef struct packed {
    logic [NEG_LN_W-1:0] neg_ln;
    logic [DRAW_W-1:0]   choice_draw;
  } step_t;

  typedef struct packed {
    logic not_empty;
    logic not_full;
  } queue_status_t;

endpackage

// ----- design/gbd_front.sv -----
// Front end: accepts draws and turns the time draw into -ln(r1) in Q.32.
module gbd_front import gbd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,
  input  queue_status_t q_status,
  output logic          push,
  output step_t         push_data
);

  localparam logic [2:0] F_IDLE = 3'd0;
  localparam logic [2:0] F_NORM = 3'd1;
  localparam logic [2:0] F_SQ   = 3'd2;
  localparam logic [2:0] F_MUL  = 3'd3;
  localparam logic [2:0] F_PUSH = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [4:0]          step_r, step_nxt;
  logic [32:0]         m_r, m_nxt;
  logic [5:0]          exp_r, exp_nxt;
  logic [LOG_BITS-1:0] frac_r, frac_nxt;
  logic [DRAW_W-1:0]   choice_r, choice_nxt;
  logic [63:0]         prod_r, prod_nxt;

  logic [32:0] x;
  logic [4:0]  sh_amt;
  logic [31:0] top;
  logic [63:0] sq;
  logic [32:0] sq_hi;
  logic [31:0] q_log;

  assign in_tready = (state_r == F_IDLE);
  assign push      = (state_r == F_PUSH) && q_status.not_full;
  assign push_data.neg_ln      = prod_r[63:LOG_BITS];
  assign push_data.choice_draw = choice_r;

  always_comb begin
    state_nxt  = state_r;
    step_nxt   = step_r;
    m_nxt      = m_r;
    exp_nxt    = exp_r;
    frac_nxt   = frac_r;
    choice_nxt = choice_r;
    prod_nxt   = prod_r;
    x      = {1'b0, in_tdata[31:0]} + 33'd1;
    sh_amt = 5'd16 >> step_r[2:0];
    top    = m_r[31:0] >> (6'd32 - {1'b0, sh_amt});
    sq     = m_r[31:0] * m_r[31:0];
    sq_hi  = sq[63:31];
    q_log  = {6'd32 - exp_r, 26'd0} - {6'd0, frac_r};
    case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          choice_nxt = in_tdata[63:32];
          frac_nxt   = '0;
          step_nxt   = '0;
          if (x[32]) begin
            // Draw of all ones: r1 is exactly one.
            m_nxt     = 33'h0_8000_0000;
            exp_nxt   = 6'd32;
            state_nxt = F_SQ;
          end else begin
            m_nxt     = x;
            exp_nxt   = 6'd31;
            state_nxt = F_NORM;
          end
        end
      end
      F_NORM: begin
        if (top == 32'd0) begin
          m_nxt   = {1'b0, m_r[31:0] << sh_amt};
          exp_nxt = exp_r - {1'b0, sh_amt};
        end
        if (step_r == 5'd4) begin
          step_nxt  = '0;
          state_nxt = F_SQ;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      F_SQ: begin
        if (sq_hi[32]) begin
          m_nxt    = {1'b0, sq_hi[32:1]};
          frac_nxt = {frac_r[LOG_BITS-2:0], 1'b1};
        end else begin
          m_nxt    = sq_hi;
          frac_nxt = {frac_r[LOG_BITS-2:0], 1'b0};
        end
        if (step_r == 5'(LOG_BITS - 1)) begin
          state_nxt = F_MUL;
        end else begin
          step_nxt = step_r + 5'd1;
        end
      end
      F_MUL: begin
        prod_nxt  = q_log * LN2_Q32;
        state_nxt = F_PUSH;
      end
      F_PUSH: begin
        if (q_status.not_full) begin
          state_nxt = F_IDLE;
        end
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    step_r   <= step_nxt;
    m_r      <= m_nxt;
    exp_r    <= exp_nxt;
    frac_r   <= frac_nxt;
    choice_r <= choice_nxt;
    prod_r   <= prod_nxt;
  end

endmodule

// ----- design/gbd_queue.sv -----
// Short queue of prepared steps between the front and back ends.
module gbd_queue import gbd_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  step_t         push_data,
  input  logic          pop,
  output step_t         pop_data,
  output queue_status_t status
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  step_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  assign status.not_empty = (count_r != '0);
  assign status.not_full  = (count_r != CNT_W'(QUEUE_DEPTH));
  assign pop_data         = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(push) - CNT_W'(pop);
    end
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- design/gbd_back.sv -----
// Back end: rates, waiting time division, count step and trajectory end.
module gbd_back import gbd_pkg::*; #(
  parameter int MAX_POPULATION     = DEF_MAX_POPULATION,
  parameter int TIME_FRACTION_BITS = DEF_TIME_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  input  queue_status_t        q_status,
  input  step_t                pop_data,
  output logic                 pop,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,
  output logic                 out_tuser
);

  localparam int SH        = TIME_FRACTION_BITS - 16;
  localparam int SH_POS    = (SH > 0) ? SH : 0;
  localparam int SH_NEG    = (SH < 0) ? -SH : 0;
  localparam int NUM_W     = 60 + SH_POS;
  localparam int DEN_W     = 51;
  localparam int DIV_STEPS = TIME_W;
  localparam logic [16:0] TGT_CAP = 17'(MAX_POPULATION - 1);

  localparam logic [3:0] B_IDLE = 4'd0;
  localparam logic [3:0] B_R1   = 4'd1;
  localparam logic [3:0] B_R2   = 4'd2;
  localparam logic [3:0] B_R3   = 4'd3;
  localparam logic [3:0] B_R4   = 4'd4;
  localparam logic [3:0] B_R5   = 4'd5;
  localparam logic [3:0] B_DIV  = 4'd6;
  localparam logic [3:0] B_UPD  = 4'd7;
  localparam logic [3:0] B_EMIT = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [POP_W-1:0]    n_r, n_nxt;
  logic [TIME_W-1:0]   t_r, t_nxt;
  logic                outcome_r, outcome_nxt;
  logic [POP_W-1:0]    target_r, target_nxt;
  logic [POP_W-1:0]    s_r, s_nxt;
  logic [NEG_LN_W-1:0] e_r, e_nxt;
  logic [DRAW_W-1:0]   choice_r, choice_nxt;
  logic [POP_W-1:0]    free_r, free_nxt;
  logic [POP_W-1:0]    occ_r, occ_nxt;
  logic [27:0]         ta_r, ta_nxt, tb_r, tb_nxt;
  logic [21:0]         nsq_r, nsq_nxt;
  logic [38:0]         pplus_r, pplus_nxt, pminus_r, pminus_nxt;
  logic [59:0]         num_r, num_nxt;
  logic [39:0]         psum_r, psum_nxt;
  logic [NUM_W-1:0]    nums_r, nums_nxt;
  logic [DEN_W-1:0]    den_r, den_nxt;
  logic [63:0]         cl_r, cl_nxt;
  logic [39:0]         ch_r, ch_nxt;
  logic                up_r, up_nxt, sat_r, sat_nxt;
  logic [DEN_W-1:0]    rem_r, rem_nxt;
  logic [TIME_W-1:0]   low_r, low_nxt;
  logic [5:0]          cnt_r, cnt_nxt;
  logic                out_valid_r;
  logic                out_tuser_r;
  logic [63:0]         out_tdata_r;

  logic [ALPHA_W-1:0] a_eff, b_eff;
  logic [POP_W-1:0]   s_c, target_c, nm1;
  logic [71:0]        choice_prod;
  logic [DEN_W:0]     r2, r2_sub;
  logic [TIME_W-1:0]  delta;
  logic [TIME_W:0]    t_sum;
  logic [TIME_W-1:0]  t_new;
  logic [POP_W-1:0]   n_new;
  logic               slot_free;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;
  assign slot_free  = !out_valid_r || out_tready;
  assign pop        = (state_r == B_IDLE) && q_status.not_empty;

  always_comb begin
    a_eff = (cfg.payoff_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.payoff_alpha;
    b_eff = ALPHA_ONE - a_eff;
    s_c   = ({1'b0, cfg.zealot_count} < cfg.population_size) ?
            cfg.population_size - {1'b0, cfg.zealot_count} : '0;
    target_c = ({6'd0, s_c} > TGT_CAP) ? TGT_CAP[POP_W-1:0] : s_c;
    nm1   = cfg.population_size - 11'd1;
    choice_prod = {ch_r, 32'd0} + {8'd0, cl_r};
    r2     = {rem_r, low_r[TIME_W-1]};
    r2_sub = r2 - {1'b0, den_r};
    delta  = sat_r ? TIME_MAX : low_r;
    t_sum  = {1'b0, t_r} + {1'b0, delta};
    t_new  = t_sum[TIME_W] ? TIME_MAX : t_sum[TIME_W-1:0];
    if (up_r) begin
      n_new = n_r + 11'd1;
    end else if (n_r != '0) begin
      n_new = n_r - 11'd1;
    end else begin
      n_new = n_r;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    n_nxt       = n_r;
    t_nxt       = t_r;
    outcome_nxt = outcome_r;
    target_nxt  = target_r;
    s_nxt       = s_r;
    e_nxt       = e_r;
    choice_nxt  = choice_r;
    free_nxt    = free_r;
    occ_nxt     = occ_r;
    ta_nxt      = ta_r;
    tb_nxt      = tb_r;
    nsq_nxt     = nsq_r;
    pplus_nxt   = pplus_r;
    pminus_nxt  = pminus_r;
    num_nxt     = num_r;
    psum_nxt    = psum_r;
    nums_nxt    = nums_r;
    den_nxt     = den_r;
    cl_nxt      = cl_r;
    ch_nxt      = ch_r;
    up_nxt      = up_r;
    sat_nxt     = sat_r;
    rem_nxt     = rem_r;
    low_nxt     = low_r;
    cnt_nxt     = cnt_r;
    case (state_r)
      B_IDLE: begin
        if (q_status.not_empty) begin
          e_nxt      = pop_data.neg_ln;
          choice_nxt = pop_data.choice_draw;
          s_nxt      = s_c;
          target_nxt = target_c;
          if (n_r >= target_c) begin
            outcome_nxt = OUTCOME_FIXATION;
            state_nxt   = B_EMIT;
          end else if (t_r >= cfg.time_limit) begin
            outcome_nxt = OUTCOME_TIMEOUT;
            state_nxt   = B_EMIT;
          end else begin
            state_nxt = B_R1;
          end
        end
      end
      B_R1: begin
        free_nxt  = s_r - n_r;
        occ_nxt   = n_r + {1'b0, cfg.zealot_count};
        ta_nxt    = 28'(a_eff) * 28'(n_r + {1'b0, cfg.zealot_count})
                  + 28'(b_eff) * 28'(s_r - n_r);
        tb_nxt    = 28'(b_eff) * 28'(n_r + {1'b0, cfg.zealot_count})
                  + 28'(a_eff) * 28'(s_r - n_r);
        nsq_nxt   = nm1 * nm1;
        state_nxt = B_R2;
      end
      B_R2: begin
        pplus_nxt  = occ_r * ta_r;
        pminus_nxt = n_r * tb_r;
        num_nxt    = e_r * nsq_r;
        state_nxt  = B_R3;
      end
      B_R3: begin
        psum_nxt = {1'b0, pplus_r} + {1'b0, pminus_r};
        if (SH >= 0) begin
          nums_nxt = NUM_W'(num_r) << SH_POS;
        end else begin
          nums_nxt = NUM_W'(num_r >> SH_NEG);
        end
        state_nxt = B_R4;
      end
      B_R4: begin
        den_nxt   = free_r * psum_r;
        cl_nxt    = choice_r * psum_r[31:0];
        ch_nxt    = choice_r * psum_r[39:32];
        state_nxt = B_R5;
      end
      B_R5: begin
        // Step up when choice * Psum <= P+ * 2^32.
        up_nxt  = (choice_prod <= {1'b0, pplus_r, 32'd0});
        // A quotient of 2^48 or more saturates; a zero rate lands here too.
        sat_nxt = ((nums_r >> TIME_W) >= NUM_W'(den_r));
        rem_nxt = DEN_W'(nums_r >> TIME_W);
        low_nxt = nums_r[TIME_W-1:0];
        cnt_nxt = '0;
        state_nxt = ((nums_r >> TIME_W) >= NUM_W'(den_r)) ? B_UPD : B_DIV;
      end
      B_DIV: begin
        if (!r2_sub[DEN_W]) begin
          rem_nxt = r2_sub[DEN_W-1:0];
          low_nxt = {low_r[TIME_W-2:0], 1'b1};
        end else begin
          rem_nxt = r2[DEN_W-1:0];
          low_nxt = {low_r[TIME_W-2:0], 1'b0};
        end
        if (cnt_r == 6'(DIV_STEPS - 1)) begin
          state_nxt = B_UPD;
        end else begin
          cnt_nxt = cnt_r + 6'd1;
        end
      end
      B_UPD: begin
        t_nxt = t_new;
        n_nxt = n_new;
        if (n_new == target_r) begin
          outcome_nxt = OUTCOME_FIXATION;
          state_nxt   = B_EMIT;
        end else if (t_new >= cfg.time_limit) begin
          outcome_nxt = OUTCOME_TIMEOUT;
          state_nxt   = B_EMIT;
        end else begin
          state_nxt = B_IDLE;
        end
      end
      B_EMIT: begin
        if (slot_free) begin
          n_nxt     = '0;
          t_nxt     = '0;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      n_r         <= '0;
      t_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      t_r     <= t_nxt;
      if ((state_r == B_EMIT) && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
    if ((state_r == B_EMIT) && slot_free) begin
      out_tuser_r <= outcome_r;
      out_tdata_r <= {6'd0, n_r[OUT_CNT_W-1:0], t_r};
    end
    outcome_r <= outcome_nxt;
    target_r  <= target_nxt;
    s_r       <= s_nxt;
    e_r       <= e_nxt;
    choice_r  <= choice_nxt;
    free_r    <= free_nxt;
    occ_r     <= occ_nxt;
    ta_r      <= ta_nxt;
    tb_r      <= tb_nxt;
    nsq_r     <= nsq_nxt;
    pplus_r   <= pplus_nxt;
    pminus_r  <= pminus_nxt;
    num_r     <= num_nxt;
    psum_r    <= psum_nxt;
    nums_r    <= nums_nxt;
    den_r     <= den_nxt;
    cl_r      <= cl_nxt;
    ch_r      <= ch_nxt;
    up_r      <= up_nxt;
    sat_r     <= sat_nxt;
    rem_r     <= rem_nxt;
    low_r     <= low_nxt;
    cnt_r     <= cnt_nxt;
  end

`include "gillespie_birth_death_stepper_assert.svh"

  `GBD_ASSERT(a_restart_clears, (state_r == B_EMIT && slot_free) |=> (n_r == '0 && t_r == '0), "trajectory not restarted after its result")
  `GBD_ASSERT(a_time_monotonic, (state_r != B_EMIT) |=> (t_r >= $past(t_r)), "trajectory time went backwards")
  `GBD_NEVER(a_div_overrun, (state_r == B_DIV) && (cnt_r >= 6'(DIV_STEPS)), "divider ran past its last step")

endmodule

// ----- design/gillespie_birth_death_stepper.sv -----
// Top level of the Gillespie birth-death stepper with configuration registers.
//
// Each request on the in_ channel carries two uniform draws and performs one
// stochastic step on the up count n and the trajectory time t. A request that
// ends a trajectory (fixation at n = N-Z, capped at MAX_POPULATION-1, or t at
// the time limit) produces one result on the out_ channel and restarts the run
// at n = 0, t = 0; all other requests produce nothing.
// The front end takes one request at a time and runs a five step leading
// zero search (skipped for the all-ones draw), 26 square-and-test rounds of
// the log unit, one multiply by ln 2 and the push. The prepared step waits in
// a two entry queue. The back end forms the waiting time of each step with
// its one-bit-per-cycle 48 step divider; a step whose quotient saturates
// skips the divider, and a request that finds the run already ended goes
// straight to the result. The front end can prepare the next request while
// the back end still works on an earlier step.
// Reset clears n, t, the queue and the output register and loads the register
// defaults. A stalled receiver holds the result in the output register; the
// front keeps accepting requests until the queue fills.
// Configuration writes on cfg_ are always taken and belong to idle periods.
module gillespie_birth_death_stepper import gbd_pkg::*; #(
  parameter int MAX_POPULATION     = DEF_MAX_POPULATION,
  parameter int TIME_FRACTION_BITS = DEF_TIME_FRACTION_BITS
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // Input requests.
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [63:0]          in_tdata,   // [31:0] time_draw, [63:32] choice_draw
  // Results.
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [63:0]          out_tdata,  // [47:0] elapsed_time, [57:48] final_up_count
  output logic                 out_tuser,  // [0] outcome
  // Register writes.
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [TIME_W-1:0]    cfg_data
);

  logic [POP_W-1:0]   population_size_r;
  logic [ZEAL_W-1:0]  zealot_count_r;
  logic [ALPHA_W-1:0] payoff_alpha_r;
  logic [TIME_W-1:0]  time_limit_r;
  cfg_t               cfg;

  queue_status_t q_status;
  logic          push, pop;
  step_t         push_data, pop_data;

  assign cfg_ready = 1'b1;
  assign cfg.population_size = population_size_r;
  assign cfg.zealot_count    = zealot_count_r;
  assign cfg.payoff_alpha    = payoff_alpha_r;
  assign cfg.time_limit      = time_limit_r;

  // Writes to indexes past the register list are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      population_size_r <= RST_POPULATION;
      zealot_count_r    <= RST_ZEALOT;
      payoff_alpha_r    <= RST_ALPHA;
      time_limit_r      <= RST_TIME_LIMIT;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_POPULATION: population_size_r <= cfg_data[POP_W-1:0];
        REG_ZEALOT:     zealot_count_r    <= cfg_data[ZEAL_W-1:0];
        REG_ALPHA:      payoff_alpha_r    <= cfg_data[ALPHA_W-1:0];
        REG_TIME_LIMIT: time_limit_r      <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  gbd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .q_status  (q_status),
    .push      (push),
    .push_data (push_data)
  );

  gbd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .status    (q_status)
  );

  gbd_back #(
    .MAX_POPULATION     (MAX_POPULATION),
    .TIME_FRACTION_BITS (TIME_FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .q_status   (q_status),
    .pop_data   (pop_data),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

// ----- sim/tb_gillespie_birth_death_stepper.sv -----
// Self-checking testbench of the Gillespie birth-death stepper.
module tb_gillespie_birth_death_stepper;
  import gbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TRAJ_MAX_POP  = DEF_MAX_POPULATION;
  localparam int FRAC_BITS     = DEF_TIME_FRACTION_BITS;
  localparam int CYCLE_LIMIT   = 3_000_000;
  localparam int SETTLE_CYCLES = 400;
  localparam int ITEM_GOAL     = 1500;

  // One finished trajectory as the block should report it.
  typedef struct {
    logic              outcome;
    logic [TIME_W-1:0] elapsed;
    logic [9:0]        up_count;
  } traj_end_t;

  // Tracks the trajectory in step with the block and compares its results.
  class trajectory_scoreboard;
    logic [POP_W-1:0]   pop_n;
    logic [ZEAL_W-1:0]  zealots;
    logic [ALPHA_W-1:0] alpha;
    logic [TIME_W-1:0]  limit;
    logic [63:0]        n_up;
    logic [TIME_W-1:0]  t_now;
    traj_end_t          ends_due[$];
    int                 errors;

    function new();
      pop_n = RST_POPULATION;
      zealots = RST_ZEALOT;
      alpha = RST_ALPHA;
      limit = RST_TIME_LIMIT;
      n_up = 0;
      t_now = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
      case (idx)
        REG_POPULATION: pop_n = val[POP_W-1:0];
        REG_ZEALOT:     zealots = val[ZEAL_W-1:0];
        REG_ALPHA:      alpha = val[ALPHA_W-1:0];
        REG_TIME_LIMIT: limit = val;
        default: ;
      endcase
    endfunction

    // -log2((draw+1)/2^32) with 26 fraction bits.
    function logic [63:0] neg_log2_q26(logic [31:0] draw);
      logic [127:0] m;
      logic [63:0]  x, e, frac;
      x = {32'd0, draw} + 64'd1;
      e = 0;
      frac = 0;
      while (e < 32 && (x >> (e + 1)) != 0) e++;
      if (e <= 31) m = {64'd0, x} << (31 - e);
      else m = {64'd0, x} >> (e - 31);
      for (int i = 0; i < LOG_BITS; i++) begin
        m = (m * m) >> 31;
        frac = frac << 1;
        if (m >= 128'h1_0000_0000) begin
          m = m >> 1;
          frac = frac | 64'd1;
        end
      end
      return (64'd32 << LOG_BITS) - ((e << LOG_BITS) | frac);
    endfunction

    function void finish_traj(logic outcome);
      traj_end_t r;
      r.outcome = outcome;
      r.elapsed = t_now;
      r.up_count = n_up[9:0];
      ends_due = {ends_due, r};
      n_up = 0;
      t_now = 0;
    endfunction

    function void note_request(logic [31:0] time_draw, logic [31:0] choice_draw);
      logic [63:0]  a, b, s, target, free_n, occ, nn, z;
      logic [127:0] pplus, pminus, psum, num, den, delta, tsum, lhs;
      nn = pop_n;
      z = zealots;
      a = (alpha > ALPHA_ONE) ? 64'd65536 : {47'd0, alpha};
      b = 64'd65536 - a;
      s = (z < nn) ? nn - z : 64'd0;
      target = (s > 64'(TRAJ_MAX_POP - 1)) ? 64'(TRAJ_MAX_POP - 1) : s;
      // A run that already sits at or past its end reports at once.
      if (n_up >= target) begin
        finish_traj(OUTCOME_FIXATION);
        return;
      end
      if (t_now >= limit) begin
        finish_traj(OUTCOME_TIMEOUT);
        return;
      end
      free_n = s - n_up;
      occ = n_up + z;
      pplus = occ * (a * occ + b * free_n);
      pminus = n_up * (b * occ + a * free_n);
      psum = pplus + pminus;
      num = ((neg_log2_q26(time_draw) * LN2_Q32) >> LOG_BITS) * ((nn - 1) * (nn - 1));
      den = free_n * psum;
      // A zero total rate saturates the waiting time.
      if (den == 0) delta = TIME_MAX;
      else begin
        delta = (num << (FRAC_BITS - 16)) / den;
        if (delta > TIME_MAX) delta = TIME_MAX;
      end
      tsum = t_now + delta;
      t_now = (tsum > TIME_MAX) ? TIME_MAX : tsum[TIME_W-1:0];
      lhs = choice_draw * psum;
      if (lhs <= (pplus << 32)) n_up = n_up + 1;
      else if (n_up > 0) n_up = n_up - 1;
      // Fixation wins over the time limit after a step.
      if (n_up == target) finish_traj(OUTCOME_FIXATION);
      else if (t_now >= limit) finish_traj(OUTCOME_TIMEOUT);
    endfunction

    function void check_result(logic outcome, logic [TIME_W-1:0] elapsed, logic [9:0] cnt);
      traj_end_t r;
      if (ends_due.size() == 0) begin
        $error("unexpected result: outcome %0d elapsed %0d count %0d", outcome, elapsed, cnt);
        errors++;
        return;
      end
      r = ends_due.pop_front();
      if (outcome !== r.outcome) begin
        $error("outcome expected %0d actual %0d", r.outcome, outcome);
        errors++;
      end
      if (elapsed !== r.elapsed) begin
        $error("elapsed_time expected %0d actual %0d", r.elapsed, elapsed);
        errors++;
      end
      if (cnt !== r.up_count) begin
        $error("final_up_count expected %0d actual %0d", r.up_count, cnt);
        errors++;
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [63:0]          in_tdata = '0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [63:0]          out_tdata;
  logic                 out_tuser;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [TIME_W-1:0]    cfg_data = '0;

  trajectory_scoreboard sb = new();
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;

  gillespie_birth_death_stepper uut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // The cycle counter guards against a hung handshake.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // The receiver stalls at random according to the current phase.
  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Every accepted request, result and register write goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (in_tvalid && in_tready) sb.note_request(in_tdata[31:0], in_tdata[63:32]);
      if (out_tvalid && out_tready)
        sb.check_result(out_tuser, out_tdata[47:0], out_tdata[57:48]);
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(int n, int z, int a, logic [TIME_W-1:0] lim);
    write_reg(REG_POPULATION, TIME_W'(n));
    write_reg(REG_ZEALOT, TIME_W'(z));
    write_reg(REG_ALPHA, TIME_W'(a));
    write_reg(REG_TIME_LIMIT, lim);
  endtask

  // Holds one request until it is taken; tvalid stays high for a follow-on unless the sender idles at random.
  task automatic send_request(logic [31:0] time_draw, logic [31:0] choice_draw);
    in_tvalid <= 1'b1;
    in_tdata <= {choice_draw, time_draw};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(10, 1)) @(posedge clk);
    end
  endtask

  // Lets every pending result arrive, then lets the pipeline empty out.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.ends_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_draw();
    case ($urandom_range(9))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int n, z, a;
    logic [TIME_W-1:0] lim;
    int phase;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: draw extremes under the reset defaults, then a run that
    // finds itself past a lowered target, the zero total rate case, alpha
    // above one, a zero limit, and the largest population.
    send_request(32'd0, 32'd0);
    send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_request(32'h8000_0000, 32'h7FFF_FFFF);
    send_request(32'h0000_0001, 32'hFFFF_FFFE);
    drain();
    set_config(2, 1, 0, TIME_MAX);
    send_request(32'h1234_5678, 32'hFFFF_FFFF);
    send_request(32'hFFFF_FFFF, 32'd0);
    send_request(32'd0, 32'h8000_0000);
    drain();
    set_config(4, 0, 65536, 48'd1 << 30);
    repeat (4) send_request($urandom, $urandom);
    drain();
    set_config(5, 2, 131071, 48'd0);
    repeat (3) send_request($urandom, $urandom);
    drain();
    // Zealots not below the population leave a target of zero.
    set_config(3, 7, 32768, TIME_MAX);
    repeat (2) send_request($urandom, $urandom);
    drain();
    set_config(1024, 1023, 0, TIME_MAX);
    repeat (3) send_request(32'hFFFF_FFFF, 32'd0);
    drain();
    set_config(1024, 1, 65536, 48'd1 << 26);
    repeat (4) send_request(32'd0, $urandom);
    drain();
    write_reg(8'hFF, TIME_W'({$urandom, $urandom}));

    // Random part: each phase picks a fresh configuration and idling mode.
    phase = 0;
    while (items_sent < ITEM_GOAL) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      case ($urandom_range(9))
        0: n = $urandom_range(1024, 2);
        1, 2: n = $urandom_range(60, 2);
        default: n = $urandom_range(12, 2);
      endcase
      case ($urandom_range(19))
        0: z = 0;
        1: z = $urandom_range(1023, n);
        default: z = $urandom_range(n - 1, 1);
      endcase
      case ($urandom_range(4))
        0: a = $urandom_range(131071);
        1: a = ($urandom_range(1)) ? 0 : 65536;
        default: a = $urandom_range(65536);
      endcase
      case ($urandom_range(9))
        0: lim = TIME_MAX;
        1: lim = TIME_W'({$urandom, $urandom});
        2: lim = TIME_W'($urandom_range(1 << 20));
        default: lim = {16'd0, $urandom} >> $urandom_range(4);
      endcase
      set_config(n, z, a, lim);
      for (int i = 0; i < 100; i++) begin
        send_request(pick_draw(), pick_draw());
        // Now and then the sender waits for every pending result.
        if ($urandom_range(49) == 0) begin
          in_tvalid <= 1'b0;
          @(posedge clk);
          while (sb.ends_due.size() != 0) @(posedge clk);
        end
      end
      drain();
      phase++;
    end

    in_tvalid <= 1'b0;
    recv_stall_pct = 0;
    drain();
    if (sb.ends_due.size() != 0) begin
      $error("%0d expected results never arrived", sb.ends_due.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
